[sv/sbi_pkg.sv]
package sbi_pkg;

  // Default table size and hold length
  localparam int unsigned MaxEventSlots = 32;
  localparam int unsigned HoldReadsDef  = 8;

  // Hold counter width (covers hold lengths up to 15)
  localparam int unsigned HoldW = 4;

  // Opcodes of an input item
  localparam logic OpLoad = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [31:0]       event_frame;
    logic [15:0]       event_mask;
    logic [31:0]       retrace_now;
    logic [15:0]       pad_buttons;
    logic signed [7:0] pad_error;
  } in_t;

  typedef struct packed {
    logic [15:0]       buttons_out;
    logic signed [7:0] error_out;
    logic              load_accepted;
    logic [31:0]       reads_total;
  } out_t;

  // One table entry as stored in the event memory
  typedef struct packed {
    logic [31:0]      start_frame;
    logic [15:0]      mask;
    logic [HoldW-1:0] hold;
  } entry_t;

  typedef enum logic [1:0] {
    StIdle,
    StLoad,
    StWalk,
    StFinish
  } state_e;

endpackage

[sv/sbi_ram.sv]
module sbi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/scheduled_button_injector.sv]
// Channel | Dir | Handshake                      | Payload
// --------+-----+--------------------------------+-----------------------
// in      | in  | in_valid_i / in_stall_o        | in_i  (sbi_pkg::in_t)
// out     | out | out_valid_o / out_stall_i      | out_o (sbi_pkg::out_t)
//
// A load goes from accept to result register through accept, table write and finish.
// A pad read with events loaded goes through accept, the walk (one read issued per
// cycle, hold count written back in the next cycle, and a closing step to end the
// walk) and finish. With no events loaded a read skips the walk.
// Reset clears the control state, event count and read counter; the table needs
// no clearing since only loaded entries are read. A stalled output holds the
// finished item; a new item is accepted meanwhile but finishes only once it drains.
module scheduled_button_injector #(
  parameter int unsigned MaxSlots  = sbi_pkg::MaxEventSlots,
  parameter int unsigned HoldReads = sbi_pkg::HoldReadsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sbi_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sbi_pkg::out_t out_o
);

  import sbi_pkg::*;

  localparam int unsigned IdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int unsigned CntW = $clog2(MaxSlots + 1);
  localparam int unsigned EntW = $bits(entry_t);

  state_e st_q, st_d;

  // Captured item and running results
  logic              op_q, op_d;
  logic [31:0]       frame_q, frame_d;
  logic [15:0]       mask_q, mask_d;
  logic [31:0]       now_q, now_d;
  logic [15:0]       btn_q, btn_d;
  logic signed [7:0] err_q, err_d;
  logic              acc_q, acc_d;

  // Table control
  logic [CntW-1:0] events_q, events_d;
  logic [31:0]     cnt_q, cnt_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic [IdxW-1:0] proc_idx_q, proc_idx_d;
  logic            pend_q, pend_d;

  // Output register
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  // Memory ports
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  entry_t          ram_wdata, ram_rent;
  logic [EntW-1:0] ram_rdata;

  logic accept, issue, inj, fire, load_ok;

  assign accept  = in_valid_i && (st_q == StIdle);
  assign issue   = rd_idx_q < events_q;
  assign fire    = !out_valid_q || !out_stall_i;
  assign load_ok = (mask_q != 16'd0) && (events_q != CntW'(MaxSlots));
  assign ram_rent = entry_t'(ram_rdata);

  // Entry injects if started or already held, and not yet finished
  assign inj = pend_q && (st_q == StWalk) &&
               !(((ram_rent.hold == '0) && (now_q < ram_rent.start_frame)) ||
                 (ram_rent.hold >= HoldW'(HoldReads)));

  sbi_ram #(
    .Width (EntW),
    .Depth (MaxSlots)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_i.opcode == OpLoad) begin
            st_d = StLoad;
          end else if (events_q != '0) begin
            st_d = StWalk;
          end else begin
            st_d = StFinish;
          end
        end
      end
      StLoad: st_d = StFinish;
      StWalk: begin
        if (!issue && !pend_q) begin
          st_d = StFinish;
        end
      end
      StFinish: begin
        if (fire) begin
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    op_d        = op_q;
    frame_d     = frame_q;
    mask_d      = mask_q;
    now_d       = now_q;
    btn_d       = btn_q;
    err_d       = err_q;
    acc_d       = acc_q;
    events_d    = events_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    proc_idx_d  = proc_idx_q;
    pend_d      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = proc_idx_q;
    ram_wdata   = ram_rent;
    ram_re      = 1'b0;
    ram_raddr   = rd_idx_q[IdxW-1:0];
    out_d       = out_q;
    out_valid_d = out_stall_i ? out_valid_q : 1'b0;
    case (st_q)
      StIdle: begin
        if (accept) begin
          op_d     = in_i.opcode;
          frame_d  = in_i.event_frame;
          mask_d   = in_i.event_mask;
          now_d    = in_i.retrace_now;
          btn_d    = in_i.pad_buttons;
          err_d    = in_i.pad_error;
          acc_d    = 1'b0;
          rd_idx_d = '0;
          if ((in_i.opcode == OpRead) && (events_q != '0)) begin
            cnt_d = cnt_q + 32'd1;
          end
        end
      end
      StLoad: begin
        // New entry always starts with a zero hold count
        acc_d     = load_ok;
        ram_we    = load_ok;
        ram_waddr = events_q[IdxW-1:0];
        ram_wdata = '{start_frame: frame_q, mask: mask_q, hold: '0};
        if (load_ok) begin
          events_d = events_q + CntW'(1);
        end
      end
      StWalk: begin
        // Issue next entry; write back the one read last cycle
        if (issue) begin
          ram_re     = 1'b1;
          pend_d     = 1'b1;
          proc_idx_d = rd_idx_q[IdxW-1:0];
          rd_idx_d   = rd_idx_q + CntW'(1);
        end
        if (inj) begin
          ram_we         = 1'b1;
          ram_wdata.hold = ram_rent.hold + HoldW'(1);
          btn_d          = btn_q | ram_rent.mask;
          err_d          = '0;
        end
      end
      StFinish: begin
        if (fire) begin
          out_valid_d = 1'b1;
          if (op_q == OpLoad) begin
            out_d = '{buttons_out: '0, error_out: '0, load_accepted: acc_q,
                      reads_total: cnt_q};
          end else begin
            out_d = '{buttons_out: btn_q, error_out: err_q, load_accepted: 1'b0,
                      reads_total: cnt_q};
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      events_q    <= '0;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      events_q    <= events_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    frame_q    <= frame_d;
    mask_q     <= mask_d;
    now_q      <= now_d;
    btn_q      <= btn_d;
    err_q      <= err_d;
    acc_q      <= acc_d;
    proc_idx_q <= proc_idx_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = (st_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Event count never passes the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    events_q <= CntW'(MaxSlots))
    else $error("event count exceeds table size");

  // Write-back never targets the entry being read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("event memory read and write collide");

  // A pending read-back only exists during the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (st_q == StWalk))
    else $error("pending entry outside walk");

  // Read counter moves only when a read is accepted with events loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !((in_i.opcode == OpRead) && (events_q != '0))) |=> $stable(cnt_q))
    else $error("read counter changed without a counted read");

endmodule

[dv/sbi_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the injector, predicts each result and compares it
module sbi_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  sbi_pkg::in_t  in_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  sbi_pkg::out_t out_i,
  output int            errors_o,
  output int            pending_o,
  output int            stored_o,
  output int            injected_o
);
  import sbi_pkg::*;

  localparam int unsigned Slots = MaxEventSlots;
  localparam int unsigned Hold  = HoldReadsDef;

  // Shadow copy of the event table
  logic [31:0]      start_frames [Slots];
  logic [15:0]      btn_masks    [Slots];
  logic [HoldW-1:0] hold_counts  [Slots];
  int unsigned      events_loaded = 0;
  logic [31:0]      read_count    = '0;

  out_t expected_outs [$];
  out_t exp_item;
  int   mismatches    = 0;
  int   pend_count    = 0;
  int   inj_reads     = 0;

  assign errors_o   = mismatches;
  assign pending_o  = pend_count;
  assign stored_o   = events_loaded;
  assign injected_o = inj_reads;

  // Apply one item to the shadow table and return the result it should cause
  function automatic out_t predict_pad_result(in_t item);
    out_t res;
    int   i;
    bit   hit;
    res = '0;
    hit = 1'b0;
    if (item.opcode == OpLoad) begin
      if (item.event_mask != '0 && events_loaded < Slots) begin
        start_frames[events_loaded] = item.event_frame;
        btn_masks[events_loaded]    = item.event_mask;
        hold_counts[events_loaded]  = '0;
        events_loaded++;
        res.load_accepted = 1'b1;
      end
    end else begin
      res.buttons_out = item.pad_buttons;
      res.error_out   = item.pad_error;
      if (events_loaded != 0) begin
        read_count++;
        for (i = 0; i < events_loaded; i++) begin
          // started or already held, and not yet finished
          if ((hold_counts[i] != '0 || item.retrace_now >= start_frames[i]) &&
              hold_counts[i] < Hold) begin
            hold_counts[i]  = hold_counts[i] + 1'b1;
            res.buttons_out = res.buttons_out | btn_masks[i];
            res.error_out   = '0;
            hit             = 1'b1;
          end
        end
      end
      if (hit) inj_reads++;
    end
    res.reads_total = read_count;
    return res;
  endfunction

  task automatic check_field(input string name, input logic signed [32:0] expv,
                             input logic signed [32:0] actv);
    if (actv !== expv) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expv, actv);
      mismatches++;
    end
  endtask

  // Results first, so an item accepted at the same edge is not matched
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      events_loaded = 0;
      read_count    = '0;
      foreach (hold_counts[k]) hold_counts[k] = '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_outs.size() == 0) begin
          $display("%0t: result with nothing expected, actual %p", $time, out_i);
          mismatches++;
        end else begin
          exp_item = expected_outs.pop_front();
          check_field("buttons_out", 33'(exp_item.buttons_out), 33'(out_i.buttons_out));
          check_field("error_out", 33'(exp_item.error_out), 33'(out_i.error_out));
          check_field("load_accepted", 33'(exp_item.load_accepted),
                      33'(out_i.load_accepted));
          check_field("reads_total", 33'(exp_item.reads_total), 33'(out_i.reads_total));
        end
      end
      if (in_valid_i && !in_stall_i) expected_outs.push_back(predict_pad_result(in_i));
      pend_count = expected_outs.size();
    end
  end

  // Anything left over at the end is reported by the top through pending_o
endmodule

[dv/tb_scheduled_button_injector.sv]
`timescale 1ns / 100ps

module tb_scheduled_button_injector;
  import sbi_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int RandItems   = 1230;
  localparam int DrainCycles = 40;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_item;
  logic        out_valid;
  logic        out_stall;
  out_t        out_item;

  int          errors;
  int          pending;
  int          stored;
  int          injected;
  int          idle_cycles;
  int          n_loads = 0;
  int          n_reads = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  logic [31:0] frame_now;

  scheduled_button_injector i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_item)
  );

  sbi_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_i        (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_i       (out_item),
    .errors_o    (errors),
    .pending_o   (pending),
    .stored_o    (stored),
    .injected_o  (injected)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Send one item after a random gap; valid stays high on back-to-back items
  task automatic send_item(input in_t item);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(19, 0);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_load(input logic [31:0] frame, input logic [15:0] mask);
    in_t item;
    item.opcode      = OpLoad;
    item.event_frame = frame;
    item.event_mask  = mask;
    item.retrace_now = $urandom();
    item.pad_buttons = 16'($urandom());
    item.pad_error   = 8'($urandom());
    n_loads++;
    send_item(item);
  endtask

  task automatic send_read(input logic [31:0] now, input logic [15:0] btn,
                           input logic signed [7:0] err);
    in_t item;
    item.opcode      = OpRead;
    item.event_frame = $urandom();
    item.event_mask  = 16'($urandom());
    item.retrace_now = now;
    item.pad_buttons = btn;
    item.pad_error   = err;
    n_reads++;
    send_item(item);
  endtask

  // Drop valid and hold off until every result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: random stall before each item, with stall-free stretches
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      if ($urandom_range(39, 0) == 0) rx_burst = !rx_burst;
      n = rx_burst ? 0 : $urandom_range(19, 0);
      @(negedge clk);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Watchdog: ends the run after too many cycles with no handshake
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int          k;
    int          sel;
    logic [31:0] frame;
    logic [31:0] now;
    logic [15:0] mask;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reads with an empty table pass through
    send_read(32'h0000_0000, 16'h0000, 8'h80);
    send_read(32'hFFFF_FFFF, 16'hFFFF, 8'h7F);
    // zero mask is rejected, table stays empty
    send_load(32'd5, 16'h0000);
    send_read(32'd10, 16'h1234, 8'hFF);
    send_load(32'd0, 16'h0001);
    send_load(32'hFFFF_FFFF, 16'h8000);
    send_load(32'd100, 16'hFFFF);
    // first event holds for its full length, then finishes
    for (k = 0; k < 7; k++) send_read(k, 16'h0000, 8'sd5);
    send_read(32'hFFFF_FFFF, 16'h0000, 8'sd9);
    // started events stay held even when the count drops below their start
    send_read(32'd3, 16'h0F00, 8'h7F);
    send_read(32'd99, 16'h00FF, 8'h80);
    // load after reads starts with a fresh hold count
    send_load(32'd200, 16'h00F0);
    send_read(32'd199, 16'h0000, 8'hF9);
    send_read(32'd200, 16'h0000, 8'hF9);

    // Random: slow loads around a running retrace count that wraps mid-run
    frame_now = 32'hFFFF_FC00;
    for (k = 0; k < RandItems; k++) begin
      if (k == 0 || k == RandItems / 2) wait_drained();
      if ($urandom_range(39, 0) == 0) tx_burst = !tx_burst;
      if ($urandom_range(29, 0) == 0) begin
        case ($urandom_range(4, 0))
          0:       frame = $urandom();
          1:       frame = frame_now - $urandom_range(20, 0);
          2:       frame = 32'hFFFF_FFFF;
          default: frame = frame_now + $urandom_range(60, 0);
        endcase
        sel = $urandom_range(9, 0);
        if (sel == 0) mask = '0;
        else if (sel == 1) mask = 16'h0001 << $urandom_range(15, 0);
        else mask = 16'($urandom_range(16'hFFFF, 1));
        send_load(frame, mask);
      end else begin
        frame_now = frame_now + $urandom_range(3, 0);
        now = ($urandom_range(39, 0) == 0) ? $urandom() : frame_now;
        send_read(now, 16'($urandom()), 8'($urandom()));
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("tb: sent %0d items: %0d loads (%0d events stored), %0d pad reads",
             n_loads + n_reads, n_loads, stored, n_reads);
    $display("tb: %0d reads had buttons injected, %0d mismatches, %0d left pending",
             injected, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
